@@ rtl/arp_cache_with_aging_unit_macros.svh @@
// assertion macros for the arp cache with aging unit
`ifndef ARP_CACHE_WITH_AGING_UNIT_MACROS_SVH
`define ARP_CACHE_WITH_AGING_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/arpc_pkg.sv @@
// shared types and constants of the arp cache
package arpc_pkg;

  localparam int ACT_W     = 2;
  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int IDX_OUT_W = 4;
  localparam int EXP_W     = 15;

  localparam logic [EXP_W-1:0] EXP_RESET = 15'd15;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  // table controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tbl_ctl_t;

endpackage

@@ rtl/arpc_ifs.sv @@
// valid/ready channel interfaces of the arp cache
interface arpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [arpc_pkg::ACT_W-1:0]  action;
  logic [arpc_pkg::IP_W-1:0]   ip_addr;
  logic [arpc_pkg::MAC_W-1:0]  mac_addr;

  modport source (output valid, output action, output ip_addr, output mac_addr, input ready);
  modport sink   (input valid, input action, input ip_addr, input mac_addr, output ready);
endinterface

interface arpc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic                            table_full;
  logic [arpc_pkg::IDX_OUT_W-1:0]  entry_index;
  logic [arpc_pkg::MAC_W-1:0]      mac_out;

  modport source (output valid, output hit, output table_full, output entry_index,
                  output mac_out, input ready);
  modport sink   (input valid, input hit, input table_full, input entry_index,
                  input mac_out, output ready);
endinterface

@@ rtl/arp_cache_with_aging_unit.sv @@
// top level of the arp binding cache with aging
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    action, ip_addr, mac_addr
//  out_ch   out  valid/ready    hit, table_full, entry_index, mac_out
//  cfg_*    in   cfg_we only    cfg_wdata = expire_ticks
//
// insert and lookup stop at the first hit, the unused action code skips the scan;
// a single slot compare unit fed by the memory read port checks one slot per cycle
// behind a registered read
// reset clears the valid bits and the time counter directly, no clearing pass
// a finished result waits in the output register while out_ch stalls; the next
// input beat is taken once the result has moved there
`include "arp_cache_with_aging_unit_macros.svh"

module arp_cache_with_aging_unit #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arpc_in_if.sink                     in_ch,
  arpc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [arpc_pkg::EXP_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // expiry setting, to be written only while the block is idle; the block does not enforce this
  logic [arpc_pkg::EXP_W-1:0] expire_r, expire_nxt;

  arpc_pkg::tbl_ctl_t         tbl_ctl;
  logic [IDX_W-1:0]           rd_addr;
  logic [IDX_W-1:0]           op_addr;
  arpc_pkg::act_t             act;
  logic [arpc_pkg::IP_W-1:0]  key_ip;
  logic [arpc_pkg::MAC_W-1:0] key_mac;
  logic [TIME_BITS-1:0]       cur_time;
  logic [arpc_pkg::IP_W-1:0]  rd_ip;
  logic [arpc_pkg::MAC_W-1:0] rd_mac;
  logic [TIME_BITS-1:0]       rd_stamp;
  logic                       op_valid;
  logic                       match;

  always_comb begin
    expire_nxt = cfg_we ? cfg_wdata : expire_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expire_r <= arpc_pkg::EXP_RESET;
    end else begin
      expire_r <= expire_nxt;
    end
  end

  // sequencer walks the slots and owns the result register
  arpc_seq #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .ctl      (tbl_ctl),
    .rd_addr  (rd_addr),
    .op_addr  (op_addr),
    .act      (act),
    .key_ip   (key_ip),
    .key_mac  (key_mac),
    .cur_time (cur_time),
    .match    (match),
    .rd_mac   (rd_mac)
  );

  // slot storage, registered read, write and clear at the compare slot
  arpc_table #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tbl_ctl),
    .rd_addr    (rd_addr),
    .op_addr    (op_addr),
    .wr_ip      (key_ip),
    .wr_mac     (key_mac),
    .wr_stamp   (cur_time),
    .rd_ip_r    (rd_ip),
    .rd_mac_r   (rd_mac),
    .rd_stamp_r (rd_stamp),
    .op_valid   (op_valid)
  );

  // one compare per cycle: free slot, ip match or expired
  arpc_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .act       (act),
    .key_ip    (key_ip),
    .ent_ip    (rd_ip),
    .ent_valid (op_valid),
    .ent_stamp (rd_stamp),
    .cur_time  (cur_time),
    .expire    (expire_r),
    .match     (match)
  );

  // assertions
  `ARPC_ASSERT_NEXT(a_busy_after_accept, rst_n && in_ch.valid && in_ch.ready, !in_ch.ready, "input taken again right after a beat")
  `ARPC_ASSERT_NOW(a_hit_not_full, out_ch.valid && out_ch.hit, !out_ch.table_full, "hit and table_full together")
  `ARPC_ASSERT_NOW(a_full_fields_zero, out_ch.valid && out_ch.table_full, (out_ch.entry_index == '0) && (out_ch.mac_out == '0), "full insert with nonzero fields")
  `ARPC_ASSERT_NEXT(a_cfg_write, rst_n && cfg_we, expire_r == $past(cfg_wdata), "expiry register missed a write")

endmodule

@@ rtl/arpc_table.sv @@
// binding storage: ip, mac and stamp memories plus per-slot valid bits
module arpc_table #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16,
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  arpc_pkg::tbl_ctl_t          ctl,
  input  logic [IDX_W-1:0]            rd_addr,
  input  logic [IDX_W-1:0]            op_addr,
  input  logic [arpc_pkg::IP_W-1:0]   wr_ip,
  input  logic [arpc_pkg::MAC_W-1:0]  wr_mac,
  input  logic [TIME_BITS-1:0]        wr_stamp,
  output logic [arpc_pkg::IP_W-1:0]   rd_ip_r,
  output logic [arpc_pkg::MAC_W-1:0]  rd_mac_r,
  output logic [TIME_BITS-1:0]        rd_stamp_r,
  output logic                        op_valid
);

  logic [arpc_pkg::IP_W-1:0]  ip_mem    [ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] mac_mem   [ENTRIES];
  logic [TIME_BITS-1:0]       stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]         valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ip_mem[op_addr]    <= wr_ip;
      mac_mem[op_addr]   <= wr_mac;
      stamp_mem[op_addr] <= wr_stamp;
    end
    if (ctl.rd_en) begin
      rd_ip_r    <= ip_mem[rd_addr];
      rd_mac_r   <= mac_mem[rd_addr];
      rd_stamp_r <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[op_addr] <= 1'b1;
    end else if (ctl.clr_en) begin
      valid_r[op_addr] <= 1'b0;
    end
  end

  assign op_valid = valid_r[op_addr];

endmodule

@@ rtl/arpc_cmp.sv @@
// shared slot test: free slot, ip match or expired age
module arpc_cmp #(
  parameter int TIME_BITS = 16
) (
  input  arpc_pkg::act_t              act,
  input  logic [arpc_pkg::IP_W-1:0]   key_ip,
  input  logic [arpc_pkg::IP_W-1:0]   ent_ip,
  input  logic                        ent_valid,
  input  logic [TIME_BITS-1:0]        ent_stamp,
  input  logic [TIME_BITS-1:0]        cur_time,
  input  logic [arpc_pkg::EXP_W-1:0]  expire,
  output logic                        match
);

  localparam int AGE_W = (TIME_BITS > arpc_pkg::EXP_W) ? TIME_BITS : arpc_pkg::EXP_W;

  logic [TIME_BITS-1:0] age;

  // age wraps with the time counter
  assign age = cur_time - ent_stamp;

  always_comb begin
    case (act)
      arpc_pkg::ACT_INSERT: match = !ent_valid;
      arpc_pkg::ACT_LOOKUP: match = ent_valid && (ent_ip == key_ip);
      arpc_pkg::ACT_TICK:   match = ent_valid && (AGE_W'(age) > AGE_W'(expire));
      default:              match = 1'b0;
    endcase
  end

endmodule

@@ rtl/arpc_seq.sv @@
// scan sequencer: slot counter, time counter and result register
module arpc_seq #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16,
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arpc_in_if.sink                     in_ch,
  arpc_out_if.source                  out_ch,
  output arpc_pkg::tbl_ctl_t          ctl,
  output logic [IDX_W-1:0]            rd_addr,
  output logic [IDX_W-1:0]            op_addr,
  output arpc_pkg::act_t              act,
  output logic [arpc_pkg::IP_W-1:0]   key_ip,
  output logic [arpc_pkg::MAC_W-1:0]  key_mac,
  output logic [TIME_BITS-1:0]        cur_time,
  input  logic                        match,
  input  logic [arpc_pkg::MAC_W-1:0]  rd_mac
);

  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int OUT_IDX_W = arpc_pkg::IDX_OUT_W;

  arpc_pkg::seq_state_t       state_r, state_nxt;
  arpc_pkg::act_t             act_r, act_nxt;
  logic [arpc_pkg::IP_W-1:0]  ip_r, ip_nxt;
  logic [arpc_pkg::MAC_W-1:0] mac_r, mac_nxt;
  logic [TIME_BITS-1:0]       time_r, time_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic                       res_hit_r, res_hit_nxt;
  logic                       res_full_r, res_full_nxt;
  logic [IDX_W-1:0]           res_idx_r, res_idx_nxt;
  logic [arpc_pkg::MAC_W-1:0] res_mac_r, res_mac_nxt;
  logic                       ov_r, ov_nxt;
  logic                       o_hit_r, o_hit_nxt;
  logic                       o_full_r, o_full_nxt;
  logic [OUT_IDX_W-1:0]       o_idx_r, o_idx_nxt;
  logic [arpc_pkg::MAC_W-1:0] o_mac_r, o_mac_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= arpc_pkg::ST_IDLE;
      time_r    <= '0;
      cmp_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    ip_r       <= ip_nxt;
    mac_r      <= mac_nxt;
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_hit_r  <= res_hit_nxt;
    res_full_r <= res_full_nxt;
    res_idx_r  <= res_idx_nxt;
    res_mac_r  <= res_mac_nxt;
    o_hit_r    <= o_hit_nxt;
    o_full_r   <= o_full_nxt;
    o_idx_r    <= o_idx_nxt;
    o_mac_r    <= o_mac_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    ip_nxt       = ip_r;
    mac_nxt      = mac_r;
    time_nxt     = time_r;
    cnt_nxt      = cnt_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    res_hit_nxt  = res_hit_r;
    res_full_nxt = res_full_r;
    res_idx_nxt  = res_idx_r;
    res_mac_nxt  = res_mac_r;
    ov_nxt       = ov_r && !out_ch.ready;
    o_hit_nxt    = o_hit_r;
    o_full_nxt   = o_full_r;
    o_idx_nxt    = o_idx_r;
    o_mac_nxt    = o_mac_r;
    ctl          = '0;

    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          act_nxt      = arpc_pkg::act_t'(in_ch.action);
          ip_nxt       = in_ch.ip_addr;
          mac_nxt      = in_ch.mac_addr;
          cnt_nxt      = '0;
          cmp_vld_nxt  = 1'b0;
          res_hit_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          res_idx_nxt  = '0;
          res_mac_nxt  = '0;
          // tick advances time before the age scan
          if (in_ch.action == arpc_pkg::ACT_TICK) begin
            time_nxt = time_r + TIME_BITS'(1);
          end
          if (in_ch.action == arpc_pkg::ACT_NONE) begin
            state_nxt = arpc_pkg::ST_DONE;
          end else begin
            state_nxt = arpc_pkg::ST_SCAN;
          end
        end
      end

      arpc_pkg::ST_SCAN: begin
        // read stage: one slot per cycle
        if (cnt_r < CNT_W'(ENTRIES)) begin
          ctl.rd_en   = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = cnt_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        // compare stage on the slot read last cycle
        if (cmp_vld_r) begin
          case (act_r)
            arpc_pkg::ACT_INSERT: begin
              if (match) begin
                ctl.wr_en   = 1'b1;
                res_idx_nxt = cmp_idx_r;
                state_nxt   = arpc_pkg::ST_DONE;
              end
            end
            arpc_pkg::ACT_LOOKUP: begin
              if (match) begin
                res_hit_nxt = 1'b1;
                res_idx_nxt = cmp_idx_r;
                res_mac_nxt = rd_mac;
                state_nxt   = arpc_pkg::ST_DONE;
              end
            end
            arpc_pkg::ACT_TICK: begin
              ctl.clr_en = match;
            end
            default: begin
            end
          endcase
          if ((cmp_idx_r == IDX_W'(ENTRIES - 1)) && (state_nxt == arpc_pkg::ST_SCAN)) begin
            state_nxt    = arpc_pkg::ST_DONE;
            res_full_nxt = (act_r == arpc_pkg::ACT_INSERT);
          end
        end
      end

      arpc_pkg::ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_hit_nxt  = res_hit_r;
          o_full_nxt = res_full_r;
          o_idx_nxt  = OUT_IDX_W'(res_idx_r);
          o_mac_nxt  = res_mac_r;
          state_nxt  = arpc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready        = (state_r == arpc_pkg::ST_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.hit         = o_hit_r;
  assign out_ch.table_full  = o_full_r;
  assign out_ch.entry_index = o_idx_r;
  assign out_ch.mac_out     = o_mac_r;

  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign op_addr  = cmp_idx_r;
  assign act      = act_r;
  assign key_ip   = ip_r;
  assign key_mac  = mac_r;
  assign cur_time = time_r;

endmodule

@@ test/arp_cache_with_aging_unit_checker.sv @@
// checker for the arp cache: predicts every reply beat and compares it with the block
module arp_cache_with_aging_unit_checker #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arpc_in_if                          in_ch,
  arpc_out_if                         out_ch,
  input  logic                        cfg_we,
  input  logic [arpc_pkg::EXP_W-1:0]  cfg_wdata,
  output int                          pending,
  output int                          fails
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                           hit;
    logic                           table_full;
    logic [arpc_pkg::IDX_OUT_W-1:0] entry_index;
    logic [arpc_pkg::MAC_W-1:0]     mac_out;
  } arp_reply_t;

  // shadow copy of the binding table
  logic                       slot_live  [ENTRIES];
  logic [arpc_pkg::IP_W-1:0]  slot_ip    [ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] slot_mac   [ENTRIES];
  logic [TIME_BITS-1:0]       slot_stamp [ENTRIES];
  logic [TIME_BITS-1:0]       now_ticks;
  logic [arpc_pkg::EXP_W-1:0] expiry;

  arp_reply_t replies_due [$];
  arp_reply_t got, want;
  int         bad_beats;

  function automatic arp_reply_t cache_step(arpc_pkg::act_t act,
                                            logic [arpc_pkg::IP_W-1:0] ip,
                                            logic [arpc_pkg::MAC_W-1:0] mac);
    arp_reply_t           r;
    logic [TIME_BITS-1:0] age;
    bit                   placed;
    r = '0;
    placed = 0;
    case (act)
      arpc_pkg::ACT_INSERT: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (!slot_live[k]) begin
            slot_ip[k]    = ip;
            slot_mac[k]   = mac;
            slot_stamp[k] = now_ticks;
            slot_live[k]  = 1'b1;
            r.entry_index = arpc_pkg::IDX_OUT_W'(k);
            placed = 1;
            break;
          end
        end
        if (!placed) r.table_full = 1'b1;
      end
      arpc_pkg::ACT_LOOKUP: begin
        for (int k = 0; k < ENTRIES; k++) begin
          if (slot_live[k] && slot_ip[k] == ip) begin
            r.hit         = 1'b1;
            r.entry_index = arpc_pkg::IDX_OUT_W'(k);
            r.mac_out     = slot_mac[k];
            break;
          end
        end
      end
      arpc_pkg::ACT_TICK: begin
        now_ticks = now_ticks + TIME_BITS'(1);
        for (int k = 0; k < ENTRIES; k++) begin
          if (slot_live[k]) begin
            age = now_ticks - slot_stamp[k];
            if (age > expiry) slot_live[k] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        slot_live[k]  = 1'b0;
        slot_ip[k]    = '0;
        slot_mac[k]   = '0;
        slot_stamp[k] = '0;
      end
      now_ticks = '0;
      expiry    = arpc_pkg::EXP_RESET;
      replies_due.delete();
    end else begin
      if (cfg_we) expiry = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.hit         = out_ch.hit;
        got.table_full  = out_ch.table_full;
        got.entry_index = out_ch.entry_index;
        got.mac_out     = out_ch.mac_out;
        if (replies_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: unexpected reply beat hit=%b full=%b idx=%0d mac=%h",
                     $realtime, got.hit, got.table_full, got.entry_index, got.mac_out);
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit || got.table_full !== want.table_full ||
              got.entry_index !== want.entry_index || got.mac_out !== want.mac_out) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display({"%0t: reply mismatch exp hit=%b full=%b idx=%0d mac=%h,",
                        " got hit=%b full=%b idx=%0d mac=%h"},
                       $realtime, want.hit, want.table_full, want.entry_index,
                       want.mac_out, got.hit, got.table_full, got.entry_index,
                       got.mac_out);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        replies_due.push_back(cache_step(arpc_pkg::act_t'(in_ch.action), in_ch.ip_addr,
                                         in_ch.mac_addr));
    end
    pending <= replies_due.size();
    fails   <= bad_beats;
  end

endmodule

@@ test/arp_cache_with_aging_unit_test.sv @@
// testbench top for the arp cache with aging: stimulus, stall patterns and verdict
module arp_cache_with_aging_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES   = 16;
  localparam int TIME_BITS = 16;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [arpc_pkg::EXP_W-1:0] cfg_wdata;
  int                         pending;
  int                         fails;

  arpc_in_if  in_ch ();
  arpc_out_if out_ch ();

  arp_cache_with_aging_unit #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  arp_cache_with_aging_unit_checker #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) scoreboard (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .fails     (fails)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sender bookkeeping
  bit  hurry;       // no gaps, no stalls: used for the age boundary run
  int  burst_left;
  int  beats_sent;
  int  ticks_total;
  int  settings_used;

  // receiver: a rotating stall mask that is reloaded with a new shape
  logic [15:0] stall_bits;
  int          rx_cycle;

  initial begin
    out_ch.ready = 1'b0;
    stall_bits   = 16'hFFFF;
    rx_cycle     = 0;
    forever begin
      @(posedge clk);
      if (rx_cycle % 96 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_bits = 16'hFFFF;        // stretch with no stalls
          2:    stall_bits = 16'hB6DB;        // scattered single-cycle stalls
          3:    stall_bits = 16'($urandom);   // random shape
          default: stall_bits = 16'hFF00;     // long stall run
        endcase
      end
      stall_bits = {stall_bits[14:0], stall_bits[15]};
      rx_cycle++;
      out_ch.ready <= hurry | stall_bits[0];
    end
  end

  // one request beat, preceded by a random gap when the current burst is used up, unless hurry is set
  task automatic send_beat(arpc_pkg::act_t act, logic [arpc_pkg::IP_W-1:0] ip,
                           logic [arpc_pkg::MAC_W-1:0] mac);
    int gap;
    if (!hurry) begin
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 30);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.ip_addr  <= ip;
    in_ch.mac_addr <= mac;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (act == arpc_pkg::ACT_TICK) ticks_total++;
  endtask

  // wait until every reply beat has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_expiry(logic [arpc_pkg::EXP_W-1:0] ticks);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // edges of the fields, duplicates, full table, misses, unused action code
  task automatic run_directed();
    send_beat(arpc_pkg::ACT_LOOKUP, '0, '0);            // lookup on an empty table
    send_beat(arpc_pkg::ACT_NONE, '1, '1);              // unused action code
    send_beat(arpc_pkg::ACT_INSERT, '0, '0);
    send_beat(arpc_pkg::ACT_INSERT, '1, '1);
    send_beat(arpc_pkg::ACT_LOOKUP, '1, '0);
    send_beat(arpc_pkg::ACT_LOOKUP, '0, '1);
    send_beat(arpc_pkg::ACT_INSERT, '1, 48'h0123_4567_89AB);  // duplicate ip
    send_beat(arpc_pkg::ACT_LOOKUP, '1, '0);            // lowest matching slot wins
    repeat (ENTRIES - 3)
      send_beat(arpc_pkg::ACT_INSERT, $urandom, {16'($urandom), 32'($urandom)});
    send_beat(arpc_pkg::ACT_INSERT, 32'hC0A8_0001, '1); // table full, dropped
    send_beat(arpc_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, '0); // miss
    send_beat(arpc_pkg::ACT_TICK, '1, '1);              // age 1, everything survives
    set_expiry('0);
    send_beat(arpc_pkg::ACT_TICK, '0, '0);              // expiry zero drops every slot
    send_beat(arpc_pkg::ACT_LOOKUP, '1, '0);
  endtask

  // random traffic: inserts and lookups mostly hit a small address pool
  task automatic run_mix(int count);
    logic [arpc_pkg::IP_W-1:0]  pool [12];
    logic [arpc_pkg::IP_W-1:0]  ip;
    logic [arpc_pkg::MAC_W-1:0] mac;
    int                         pick;
    int                         sub;
    for (int j = 0; j < 12; j++) pool[j] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      mac  = {16'($urandom), 32'($urandom)};
      ip   = pool[$urandom_range(0, 11)];
      if (pick < 35) begin
        if (sub >= 85) ip = $urandom;
        send_beat(arpc_pkg::ACT_INSERT, ip, mac);
      end else if (pick < 75) begin
        if (sub >= 90) ip = $urandom;
        else if (sub >= 78) ip = ip ^ (32'd1 << $urandom_range(0, 31));  // near miss
        send_beat(arpc_pkg::ACT_LOOKUP, ip, mac);
      end else if (pick < 95) begin
        send_beat(arpc_pkg::ACT_TICK, $urandom, mac);
      end else begin
        send_beat(arpc_pkg::ACT_NONE, $urandom, mac);
      end
    end
  endtask

  // age boundary back to back: exactly at the limit survives, one past drops
  task automatic run_age_edge();
    logic [arpc_pkg::IP_W-1:0] w0, w1;
    w0 = $urandom;
    w1 = w0 ^ 32'h8000_0001;
    hurry = 1;
    set_expiry('0);
    send_beat(arpc_pkg::ACT_TICK, '0, '0);              // empty the table
    set_expiry(15'd20);
    send_beat(arpc_pkg::ACT_INSERT, w0, {16'($urandom), 32'($urandom)});
    send_beat(arpc_pkg::ACT_INSERT, w1, {16'($urandom), 32'($urandom)});
    repeat (20) send_beat(arpc_pkg::ACT_TICK, '0, '0);  // age 20
    send_beat(arpc_pkg::ACT_LOOKUP, w0, '0);
    send_beat(arpc_pkg::ACT_LOOKUP, w1, '0);
    send_beat(arpc_pkg::ACT_TICK, '0, '0);              // age 21
    send_beat(arpc_pkg::ACT_LOOKUP, w1, '0);
    drain();
    hurry = 0;
  endtask

  logic [arpc_pkg::EXP_W-1:0] expiry_plan [6];

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = arpc_pkg::ACT_NONE;
    in_ch.ip_addr  = '0;
    in_ch.mac_addr = '0;
    hurry          = 0;
    burst_left     = 0;
    beats_sent     = 0;
    ticks_total    = 0;
    settings_used  = 0;
    expiry_plan    = '{15'd15, 15'd0, 15'h7FFF, 15'd1, 15'd4,
                       15'($urandom_range(2, 60))};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    foreach (expiry_plan[p]) begin
      set_expiry(expiry_plan[p]);
      run_mix(140);
    end
    run_age_edge();

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d request beats (%0d ticks) over %0d expiry settings",
             beats_sent, ticks_total, settings_used);
    $display("including full table, duplicates, expiry 0 and max, age limit boundary");
    if (fails == 0 && pending == 0) begin
      $display("arp_cache_with_aging_unit_test: PASS");
    end else begin
      $display("arp_cache_with_aging_unit_test: FAIL");
    end
    $finish;
  end

  // a run that never finishes is ended here and reported as FAIL
  initial begin
    #10ms;
    $display("arp_cache_with_aging_unit_test: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ifs.sv
rtl/arpc_table.sv
rtl/arpc_cmp.sv
rtl/arpc_seq.sv
rtl/arp_cache_with_aging_unit.sv
test/arp_cache_with_aging_unit_checker.sv
test/arp_cache_with_aging_unit_test.sv
